@@ hdl/fvn_pkg.sv @@
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, constants and helper functions of the fractal value noise core
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int MAX_OCTAVES = 16;
    localparam int COS_BITS    = 8;
    localparam int FRAC_BITS   = 16;

    localparam int COS_ENTRIES = 1 << COS_BITS;
    localparam int W_BITS      = FRAC_BITS + 1;
    localparam int OCT_BITS    = $clog2(MAX_OCTAVES + 1);
    localparam int GAIN_BITS   = 41;
    localparam int TOTAL_BITS  = 48;
    localparam int VAL_BITS    = 18;
    localparam int NODES       = 16;

    localparam logic [63:0] PI_Q28 = 64'd843314857;
    localparam logic signed [GAIN_BITS-1:0] GAIN_MAX = (GAIN_BITS)'((64'sd1 <<< 40) - 1);

    // blend modes
    localparam logic [1:0] BLEND_NONE   = 2'd0;
    localparam logic [1:0] BLEND_LINEAR = 2'd1;
    localparam logic [1:0] BLEND_COSINE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_AMPLITUDE   = 3'd0;
    localparam logic [2:0] REG_BASE_FREQ   = 3'd1;
    localparam logic [2:0] REG_PHASE_X     = 3'd2;
    localparam logic [2:0] REG_PHASE_Y     = 3'd3;
    localparam logic [2:0] REG_PERSISTENCE = 3'd4;
    localparam logic [2:0] REG_OCTAVES     = 3'd5;
    localparam logic [2:0] REG_BLEND_MODE  = 3'd6;
    localparam logic [2:0] REG_SMOOTHING   = 3'd7;

    typedef logic [W_BITS-1:0] t_cos_rom [COS_ENTRIES];

    typedef struct packed {
        logic [16:0]         persistence;
        logic [OCT_BITS-1:0] count;
        logic [1:0]          blend_mode;
        logic                smoothing;
    } t_cfg;

    typedef struct packed {
        logic                          valid;
        logic [63:0]                   sx;
        logic [63:0]                   sy;
        logic signed [GAIN_BITS-1:0]   gain;
        logic signed [TOTAL_BITS-1:0]  total;
    } t_link;

    function automatic t_cos_rom f_build_cos_rom();
        t_cos_rom    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      c;
        longint      d;
        logic [63:0] du;
        for (int k = 0; k < COS_ENTRIES; k++) begin
            x    = (PI_Q28 * 64'(k)) >> COS_BITS;
            x2   = (x * x) >> 28;
            term = 64'd1 << 28;
            c    = longint'(term);
            for (int n = 1; n <= 14; n++) begin
                term = ((term * x2) >> 28) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    c = c - longint'(term);
                end else begin
                    c = c + longint'(term);
                end
            end
            d = (longint'(1) <<< 28) - c;
            if (d < 0) begin
                d = 0;
            end
            if (d > (longint'(1) <<< 29)) begin
                d = longint'(1) <<< 29;
            end
            du = 64'(d);
            rom[k] = W_BITS'(((du << FRAC_BITS) + (64'd1 << 28)) >> 29);
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = f_build_cos_rom();

    function automatic logic [31:0] f_hash_mul(input logic [2:0] cls);
        case (cls)
            3'd0:    return 32'd53;
            3'd1:    return 32'd61;
            3'd2:    return 32'd47;
            3'd3:    return 32'd67;
            3'd4:    return 32'd43;
            default: return 32'd59;
        endcase
    endfunction

    function automatic logic [4:0] f_hash_shift(input logic [2:0] cls);
        case (cls)
            3'd0:    return 5'd13;
            3'd1:    return 5'd11;
            3'd2:    return 5'd15;
            3'd3:    return 5'd17;
            3'd4:    return 5'd13;
            default: return 5'd7;
        endcase
    endfunction

    function automatic logic [31:0] f_hash_a(input logic [2:0] cls);
        case (cls)
            3'd0:    return 32'd15731;
            3'd1:    return 32'd15683;
            3'd2:    return 32'd15733;
            3'd3:    return 32'd15761;
            3'd4:    return 32'd15787;
            default: return 32'd15667;
        endcase
    endfunction

    function automatic logic [31:0] f_hash_b(input logic [2:0] cls);
        case (cls)
            3'd0:    return 32'd789221;
            3'd1:    return 32'd789017;
            3'd2:    return 32'd789121;
            3'd3:    return 32'd789673;
            3'd4:    return 32'd789251;
            default: return 32'd789323;
        endcase
    endfunction

    function automatic logic [31:0] f_hash_c(input logic [2:0] cls);
        case (cls)
            3'd0:    return 32'd1376312579;
            3'd1:    return 32'd1376311273;
            3'd2:    return 32'd1376313067;
            3'd3:    return 32'd1376318989;
            3'd4:    return 32'd1376312689;
            default: return 32'd1376313793;
        endcase
    endfunction

    // lattice value in q.16 from the hash word
    function automatic logic signed [VAL_BITS-1:0] f_lattice(input logic [31:0] h);
        return VAL_BITS'(18'sd65536 - $signed({1'b0, h[30:14]}));
    endfunction

    // a + floor((b - a) * w / 2^frac)
    function automatic logic signed [VAL_BITS-1:0] f_mix(
        input logic signed [VAL_BITS-1:0] a,
        input logic signed [VAL_BITS-1:0] b,
        input logic [W_BITS-1:0]          w
    );
        logic signed [VAL_BITS:0]              diff;
        logic signed [VAL_BITS+W_BITS+1:0]     prod;
        logic signed [VAL_BITS+W_BITS+1:0]     sum;
        diff = $signed({b[VAL_BITS-1], b}) - $signed({a[VAL_BITS-1], a});
        prod = diff * $signed({1'b0, w});
        sum  = (prod >>> FRAC_BITS) + a;
        return sum[VAL_BITS-1:0];
    endfunction

endpackage

@@ hdl/fvn_cell.sv @@
// ----------------------------------------------------------------------------
// fvn_cell
// One octave of the noise sum: hash lattice, smoothing, blend, gain and add
// ----------------------------------------------------------------------------
module fvn_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [fvn_pkg::OCT_BITS-1:0]  i_octave,
    input  logic [2:0]                    i_class,
    input  fvn_pkg::t_cfg                 i_cfg,
    input  fvn_pkg::t_link                i_link,
    output fvn_pkg::t_link                o_link
);

    localparam int VB = fvn_pkg::VAL_BITS;
    localparam int WB = fvn_pkg::W_BITS;

    // stage a: lattice indices, weights, octave gain, hash pre-mix
    logic [31:0]                          ix, iy, fx, fy;
    logic [31:0]                          n_n [fvn_pkg::NODES];
    logic [WB-1:0]                        n_wx, n_wy;
    logic signed [fvn_pkg::GAIN_BITS+17:0] gp;
    logic signed [fvn_pkg::GAIN_BITS+17:0] gs;
    logic signed [fvn_pkg::GAIN_BITS-1:0] n_gain;
    fvn_pkg::t_link                       n_a_link;

    always_comb begin
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] nn;
        ix = i_link.sx[63:32];
        iy = i_link.sy[63:32];
        fx = i_link.sx[31:0];
        fy = i_link.sy[31:0];
        for (int dy = 0; dy < 4; dy++) begin
            for (int dx = 0; dx < 4; dx++) begin
                cx = ix + 32'(dx - 1);
                cy = iy + 32'(dy - 1);
                nn = cx + cy * fvn_pkg::f_hash_mul(i_class);
                n_n[dy * 4 + dx] = (nn << fvn_pkg::f_hash_shift(i_class)) ^ nn;
            end
        end
        if (i_cfg.blend_mode == fvn_pkg::BLEND_COSINE) begin
            n_wx = fvn_pkg::COS_ROM[fx[31 -: fvn_pkg::COS_BITS]];
            n_wy = fvn_pkg::COS_ROM[fy[31 -: fvn_pkg::COS_BITS]];
        end else begin
            n_wx = {1'b0, fx[31 -: fvn_pkg::FRAC_BITS]};
            n_wy = {1'b0, fy[31 -: fvn_pkg::FRAC_BITS]};
        end
        gp = i_link.gain * $signed({1'b0, i_cfg.persistence});
        gs = gp >>> 16;
        if (i_octave == '0) begin
            n_gain = i_link.gain;
        end else if (gs > fvn_pkg::GAIN_MAX) begin
            n_gain = fvn_pkg::GAIN_MAX;
        end else if (gs < -fvn_pkg::GAIN_MAX) begin
            n_gain = -fvn_pkg::GAIN_MAX;
        end else begin
            n_gain = gs[fvn_pkg::GAIN_BITS-1:0];
        end
        n_a_link      = i_link;
        n_a_link.sx   = i_link.sx << 1;
        n_a_link.sy   = i_link.sy << 1;
        n_a_link.gain = n_gain;
    end

    fvn_pkg::t_link r_a_link, r_b_link, r_c_link, r_d_link, r_e_link, r_f_link, r_g_link;
    fvn_pkg::t_link r_h_link;
    logic [WB-1:0]  r_a_wx, r_a_wy, r_b_wx, r_b_wy, r_c_wx, r_c_wy;
    logic [WB-1:0]  r_d_wx, r_d_wy, r_e_wx, r_e_wy, r_f_wy;
    logic [31:0]    r_a_n [fvn_pkg::NODES];
    logic [31:0]    r_b_n [fvn_pkg::NODES];
    logic [31:0]    r_b_sq [fvn_pkg::NODES];
    logic [31:0]    r_c_n [fvn_pkg::NODES];
    logic [31:0]    r_c_p [fvn_pkg::NODES];
    logic [31:0]    r_d_h [fvn_pkg::NODES];
    logic signed [VB-1:0] r_e_node [4];
    logic signed [VB-1:0] r_f_r0, r_f_r1, r_g_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_link.valid <= 1'b0;
        end else if (i_en) begin
            r_a_link       <= n_a_link;
            r_a_wx         <= n_wx;
            r_a_wy         <= n_wy;
            r_a_n          <= n_n;
        end
    end

    // stage b: n * n
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_link.valid <= 1'b0;
        end else if (i_en) begin
            r_b_link <= r_a_link;
            r_b_wx   <= r_a_wx;
            r_b_wy   <= r_a_wy;
            r_b_n    <= r_a_n;
            for (int j = 0; j < fvn_pkg::NODES; j++) begin
                r_b_sq[j] <= r_a_n[j] * r_a_n[j];
            end
        end
    end

    // stage c: n * n * a + b
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_link.valid <= 1'b0;
        end else if (i_en) begin
            r_c_link <= r_b_link;
            r_c_wx   <= r_b_wx;
            r_c_wy   <= r_b_wy;
            r_c_n    <= r_b_n;
            for (int j = 0; j < fvn_pkg::NODES; j++) begin
                r_c_p[j] <= r_b_sq[j] * fvn_pkg::f_hash_a(i_class)
                            + fvn_pkg::f_hash_b(i_class);
            end
        end
    end

    // stage d: final hash word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_link.valid <= 1'b0;
        end else if (i_en) begin
            r_d_link <= r_c_link;
            r_d_wx   <= r_c_wx;
            r_d_wy   <= r_c_wy;
            for (int j = 0; j < fvn_pkg::NODES; j++) begin
                r_d_h[j] <= r_c_n[j] * r_c_p[j] + fvn_pkg::f_hash_c(i_class);
            end
        end
    end

    // stage e: lattice values and optional 3x3 smoothing of the four corners
    logic signed [VB-1:0] lat [fvn_pkg::NODES];
    logic signed [VB-1:0] n_node [4];

    always_comb begin
        logic signed [VB+5:0] acc;
        int                   ty;
        int                   tx;
        for (int j = 0; j < fvn_pkg::NODES; j++) begin
            lat[j] = fvn_pkg::f_lattice(r_d_h[j]);
        end
        for (int q = 0; q < 4; q++) begin
            ty = q / 2 + 1;
            tx = q % 2 + 1;
            acc = '0;
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    if (dx == 0 && dy == 0) begin
                        acc = acc + ((VB+6)'(lat[ty * 4 + tx]) <<< 2);
                    end else if (dx == 0 || dy == 0) begin
                        acc = acc + ((VB+6)'(lat[(ty + dy) * 4 + tx + dx]) <<< 1);
                    end else begin
                        acc = acc + (VB+6)'(lat[(ty + dy) * 4 + tx + dx]);
                    end
                end
            end
            if (r_d_link.valid && i_cfg.smoothing) begin
                n_node[q] = VB'(acc >>> 4);
            end else begin
                n_node[q] = lat[ty * 4 + tx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_link.valid <= 1'b0;
        end else if (i_en) begin
            r_e_link <= r_d_link;
            r_e_wx   <= r_d_wx;
            r_e_wy   <= r_d_wy;
            r_e_node <= n_node;
        end
    end

    // stage f: blend along x for both rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_link.valid <= 1'b0;
        end else if (i_en) begin
            r_f_link <= r_e_link;
            r_f_wy   <= r_e_wy;
            r_f_r0   <= fvn_pkg::f_mix(r_e_node[0], r_e_node[1], r_e_wx);
            r_f_r1   <= fvn_pkg::f_mix(r_e_node[2], r_e_node[3], r_e_wx);
        end
    end

    // stage g: blend along y in linear or cosine mode, zero in any other mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_link.valid <= 1'b0;
        end else if (i_en) begin
            r_g_link <= r_f_link;
            if (i_cfg.blend_mode == fvn_pkg::BLEND_LINEAR ||
                i_cfg.blend_mode == fvn_pkg::BLEND_COSINE) begin
                r_g_v <= fvn_pkg::f_mix(r_f_r0, r_f_r1, r_f_wy);
            end else begin
                r_g_v <= '0;
            end
        end
    end

    // stage h: weight by the octave gain and accumulate, for octaves below the count only
    logic signed [VB+fvn_pkg::GAIN_BITS-1:0] term_prod;
    logic signed [VB+fvn_pkg::GAIN_BITS-1:0] term;
    fvn_pkg::t_link                          n_h_link;

    always_comb begin
        term_prod = r_g_v * r_g_link.gain;
        term      = term_prod >>> 16;
        n_h_link  = r_g_link;
        if (i_octave < i_cfg.count) begin
            n_h_link.total = r_g_link.total + fvn_pkg::TOTAL_BITS'(term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_link.valid <= 1'b0;
        end else if (i_en) begin
            r_h_link <= n_h_link;
        end
    end

    assign o_link = r_h_link;

endmodule

@@ hdl/fractal_value_noise_2d_core.sv @@
// throughput: one sample per cycle; every octave cell is an 8-stage pipeline
// the whole pipeline holds while the output register is full and not taken
// reset (synchronous, active low) clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_core
// Fractal 2D value noise: phase, frequency scale and a row of octave cells
// ----------------------------------------------------------------------------
module fractal_value_noise_2d_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // x_coord [31:0], y_coord [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // noise_sum [31:0]
);

    logic signed [23:0] r_amplitude;
    logic [23:0]        r_base_freq;
    logic [31:0]        r_phase_x, r_phase_y;
    logic [16:0]        r_persistence;
    logic [4:0]         r_octaves;
    logic [1:0]         r_blend_mode;
    logic               r_smoothing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude   <= 24'sd65536;
            r_base_freq   <= 24'd65536;
            r_phase_x     <= '0;
            r_phase_y     <= '0;
            r_persistence <= 17'd32768;
            r_octaves     <= 5'd4;
            r_blend_mode  <= fvn_pkg::BLEND_LINEAR;
            r_smoothing   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fvn_pkg::REG_AMPLITUDE:   r_amplitude   <= i_cfg_data[23:0];
                fvn_pkg::REG_BASE_FREQ:   r_base_freq   <= i_cfg_data[23:0];
                fvn_pkg::REG_PHASE_X:     r_phase_x     <= i_cfg_data;
                fvn_pkg::REG_PHASE_Y:     r_phase_y     <= i_cfg_data;
                fvn_pkg::REG_PERSISTENCE: r_persistence <= i_cfg_data[16:0];
                fvn_pkg::REG_OCTAVES:     r_octaves     <= i_cfg_data[4:0];
                fvn_pkg::REG_BLEND_MODE:  r_blend_mode  <= i_cfg_data[1:0];
                fvn_pkg::REG_SMOOTHING:   r_smoothing   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    fvn_pkg::t_cfg cfg;
    always_comb begin
        cfg.persistence = r_persistence;
        cfg.blend_mode  = r_blend_mode;
        cfg.smoothing   = r_smoothing;
        if (32'(r_octaves) > 32'(fvn_pkg::MAX_OCTAVES)) begin
            cfg.count = fvn_pkg::OCT_BITS'(fvn_pkg::MAX_OCTAVES);
        end else begin
            cfg.count = fvn_pkg::OCT_BITS'(r_octaves);
        end
    end

    logic en;
    logic r_out_valid;
    logic [31:0] r_out_data;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // phase add, then frequency scale into q.32 lattice coordinates
    logic        r_p_valid;
    logic [31:0] r_px, r_py;
    fvn_pkg::t_link link [fvn_pkg::MAX_OCTAVES + 1];
    fvn_pkg::t_link r_s_link;
    logic signed [56:0] px_f, py_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= s_axis_tvalid;
            r_px      <= s_axis_tdata[31:0] + r_phase_x;
            r_py      <= s_axis_tdata[63:32] + r_phase_y;
        end
    end

    // signed 32 x unsigned 24 product
    always_comb begin
        px_f = $signed(r_px) * $signed({1'b0, r_base_freq});
        py_f = $signed(r_py) * $signed({1'b0, r_base_freq});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_link.valid <= 1'b0;
        end else if (en) begin
            r_s_link.valid <= r_p_valid;
            r_s_link.sx    <= 64'(px_f);
            r_s_link.sy    <= 64'(py_f);
            r_s_link.gain  <= fvn_pkg::GAIN_BITS'(r_amplitude);
            r_s_link.total <= '0;
        end
    end

    assign link[0] = r_s_link;

    for (genvar k = 0; k < fvn_pkg::MAX_OCTAVES; k++) begin : g_cell
        fvn_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_octave (fvn_pkg::OCT_BITS'(k)),
            .i_class  (3'(k % 6)),
            .i_cfg    (cfg),
            .i_link   (link[k]),
            .o_link   (link[k + 1])
        );
    end

    fvn_pkg::t_link last;
    assign last = link[fvn_pkg::MAX_OCTAVES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
            if (last.total > 48'sh0000_7fff_ffff) begin
                r_out_data <= 32'h7fff_ffff;
            end else if (last.total < -48'sh0000_8000_0000) begin
                r_out_data <= 32'h8000_0000;
            end else begin
                r_out_data <= last.total[31:0];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_result_from_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(last.valid))
        else $error("result without a sample at the end of the chain");

    a_count_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(cfg.count) <= 32'(fvn_pkg::MAX_OCTAVES))
        else $error("octave count above limit");

endmodule
